[rtl/rc4_stream_cipher_assert.svh]
// Assertion macros for the RC4 cipher block (clock clk, reset rst_n).
`ifndef RC4_STREAM_CIPHER_ASSERT_SVH
`define RC4_STREAM_CIPHER_ASSERT_SVH
`ifndef ASSERT_OFF
`define RC4_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("rc4 assertion failed");
`define RC4_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("rc4 assertion failed");
`else
`define RC4_ASSERT_IMP(lbl, ant, cons)
`define RC4_ASSERT_NEXT(lbl, ant, cons)
`endif
`endif

[rtl/rc4_pkg.sv]
// Shared types and constants for the RC4 cipher block.
package rc4_pkg;
  localparam int BYTE_W            = 8;
  localparam int TABLE_DEPTH       = 256;
  localparam int MAX_KEY_BYTES_DEF = 256;

  typedef logic [BYTE_W-1:0] byte_t;

  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_DATA = 1'b1;
endpackage

[rtl/rc4_stream_cipher.sv]
// RC4 cipher: a data item runs through the S_KS_J, S_KS_SWAP and S_KS_OUT states to out_valid,
// the read i / read j / swap sequence on the single-write-port state RAM; a new item is taken
// only in idle or as the last result is produced. A key byte that is not the last leaves the
// block in idle. Last key byte: table fill, then key schedule (S_SCH_RD, S_SCH_J, S_SCH_WN,
// S_SCH_WJ per swap pass), no items accepted meanwhile. Reset (sync, rst_n low): i=1, j=0,
// key count 0, then an identity fill of the state table before the first item is accepted.
module rc4_stream_cipher import rc4_pkg::*; #(
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  logic  in_kind,
  input  byte_t in_value,
  input  logic  in_last,
  output logic  out_valid,
  input  logic  out_stall,
  output byte_t out_byte,
  output logic  out_last
);
  localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int KCW    = $clog2(MAX_KEY_BYTES + 1);
  localparam logic [KCW-1:0] KEY_MAX = KCW'(MAX_KEY_BYTES);

  typedef enum logic [3:0] {
    S_FILL, S_IDLE, S_KS_J, S_KS_SWAP, S_KS_OUT,
    S_SCH_RD, S_SCH_J, S_SCH_WN, S_SCH_WJ
  } state_t;

  state_t          state_r;
  byte_t           n_r, i_r, j_r, a_r, b_r, t_r, val_r;
  logic            sched_r, fwd_r, last_r;
  logic [KEY_AW-1:0] k_r;
  logic [KCW-1:0]  key_count_r;
  logic            out_valid_r, out_last_r;
  byte_t           out_byte_r;

  // state table RAM
  logic            pwe;
  byte_t           pwaddr, pwdata, praddr, prdata;
  // key store RAM
  logic            kwe;
  byte_t           krdata;

  logic            out_free, in_acc, key_room, sched_done;
  byte_t           i_next, a_cur, kb, j_sch, ks;
  logic [KCW-1:0]  key_count_upd, k_inc;
  state_t          acc_state;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) || (state_r == S_KS_OUT && out_free));
  assign in_acc   = in_valid && !in_stall;
  assign i_next   = i_r + 8'd1;
  assign a_cur    = fwd_r ? a_r : prdata;
  assign kb       = (key_count_r != '0) ? krdata : '0;
  assign j_sch    = j_r + kb + prdata;
  assign key_room = key_count_r < KEY_MAX;
  assign kwe      = in_acc && in_kind == KIND_KEY && key_room;
  assign key_count_upd = kwe ? key_count_r + KCW'(1) : key_count_r;
  assign k_inc    = KCW'(k_r) + KCW'(1);
  assign sched_done = (state_r == S_SCH_WJ) && (n_r == 8'hff);
  // where an accepted item sends the sequencer
  assign acc_state = (in_kind == KIND_DATA) ? S_KS_J : (in_last ? S_FILL : S_IDLE);

  // keystream byte: S[j] = a and S[i] = b may not have reached the read data yet
  assign ks = (t_r == j_r) ? a_r : ((t_r == i_r) ? b_r : prdata);

  always_comb begin
    pwe    = 1'b0;
    pwaddr = n_r;
    pwdata = n_r;
    praddr = i_r;
    case (state_r)
      S_FILL: begin
        pwe = 1'b1;
      end
      S_IDLE: begin
        praddr = i_r;
      end
      S_KS_J: begin
        praddr = j_r + a_cur;
      end
      S_KS_SWAP: begin
        pwe    = 1'b1;
        pwaddr = i_r;
        pwdata = prdata;
        praddr = a_r + prdata;
      end
      S_KS_OUT: begin
        pwe    = 1'b1;
        pwaddr = j_r;
        pwdata = a_r;
        praddr = out_free ? i_next : t_r;
      end
      S_SCH_RD: begin
        praddr = n_r;
      end
      S_SCH_J: begin
        praddr = j_sch;
      end
      S_SCH_WN: begin
        pwe    = 1'b1;
        pwaddr = n_r;
        pwdata = prdata;
      end
      S_SCH_WJ: begin
        pwe    = 1'b1;
        pwaddr = j_r;
        pwdata = a_r;
      end
      default: begin
        pwe = 1'b0;
      end
    endcase
  end

  rc4_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_DEPTH)) u_perm_ram (
    .clk   (clk),
    .we    (pwe),
    .waddr (pwaddr),
    .wdata (pwdata),
    .raddr (praddr),
    .rdata (prdata)
  );

  rc4_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_KEY_BYTES)) u_key_ram (
    .clk   (clk),
    .we    (kwe),
    .waddr (key_count_r[KEY_AW-1:0]),
    .wdata (in_value),
    .raddr (k_r),
    .rdata (krdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      n_r         <= '0;
      sched_r     <= 1'b0;
      i_r         <= 8'd1;
      j_r         <= '0;
      k_r         <= '0;
      key_count_r <= '0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_KS_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_FILL: begin
          n_r <= n_r + 8'd1;
          if (n_r == 8'hff) begin
            if (sched_r) begin
              state_r <= S_SCH_RD;
              j_r     <= '0;
              k_r     <= '0;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            state_r <= acc_state;
          end
        end
        S_KS_J: begin
          a_r     <= a_cur;
          j_r     <= j_r + a_cur;
          state_r <= S_KS_SWAP;
        end
        S_KS_SWAP: begin
          b_r     <= prdata;
          t_r     <= a_r + prdata;
          state_r <= S_KS_OUT;
        end
        S_KS_OUT: begin
          if (out_free) begin
            out_byte_r  <= val_r ^ ks;
            out_last_r  <= last_r;
            i_r         <= i_next;
            state_r     <= in_acc ? acc_state : S_IDLE;
          end
        end
        S_SCH_RD: begin
          state_r <= S_SCH_J;
        end
        S_SCH_J: begin
          a_r     <= prdata;
          j_r     <= j_sch;
          state_r <= S_SCH_WN;
        end
        S_SCH_WN: begin
          state_r <= S_SCH_WJ;
        end
        S_SCH_WJ: begin
          n_r <= n_r + 8'd1;
          if (k_inc >= key_count_r) begin
            k_r <= '0;
          end else begin
            k_r <= k_inc[KEY_AW-1:0];
          end
          if (n_r == 8'hff) begin
            state_r     <= S_IDLE;
            i_r         <= 8'd1;
            j_r         <= '0;
            key_count_r <= '0;
            sched_r     <= 1'b0;
          end else begin
            state_r <= S_SCH_RD;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      // new item, taken in idle or alongside a finishing result
      if (in_acc) begin
        if (in_kind == KIND_DATA) begin
          val_r   <= in_value;
          last_r  <= in_last;
          fwd_r   <= (state_r == S_KS_OUT) && (i_next == j_r);
        end else begin
          key_count_r <= key_count_upd;
          if (in_last) begin
            sched_r <= 1'b1;
            n_r     <= '0;
          end
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

`include "rc4_stream_cipher_assert.svh"

  `RC4_ASSERT_NEXT(a_result_loaded, (state_r == S_KS_OUT && out_free), out_valid)
  `RC4_ASSERT_IMP(a_key_count_bound, 1'b1, (key_count_r <= KEY_MAX))
  `RC4_ASSERT_NEXT(a_sched_end_state, sched_done, (i_r == 8'd1 && j_r == '0 && key_count_r == '0))
endmodule

[rtl/rc4_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
